// File: hw/rtl/swm_pkg.sv
// shared types and constants of the sliding window median filter
package swm_pkg;

   // fixed field widths of the stream words and registers
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 48;
   localparam int FILL_W   = 13;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int WSIZE_W  = 11;

   // register index of window_size
   localparam logic CSR_IDX_WINDOW_SIZE = 1'b0;

   // engine sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAIN_CHK,
      ST_DRAIN_RD,
      ST_PREP,
      ST_OLD_RD,
      ST_WALK,
      ST_INS,
      ST_POST,
      ST_RANK_START,
      ST_RANK,
      ST_RESULT
   } swm_state_type;

   // one result word
   typedef struct packed {
      logic [SUM_W-1:0]    median_sum;
      logic [SAMPLE_W-1:0] median;
   } swm_rsp_type;

   // engine status toward the top level
   typedef struct packed {
      logic              init;
      logic              busy;
      logic [FILL_W-1:0] fill;
   } swm_status_type;

endpackage

// File: hw/rtl/sliding_window_median_top.sv
// Items that do not yet fill the window skip removal and the rank walk.
// A restart or window_size write makes the next item first take every held sample back out of the trie.
// The engine takes a new item only once it is through with the last one.
// After reset the count memory is zeroed; items queue meanwhile.
// Synchronous active high reset; window_size resets to 1.
module sliding_window_median_top #(
   parameter int VALUE_BITS = 16,
   parameter int WINDOW_MAX = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // sample
   input  logic                          req_tuser,   // restart
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [63:0]                   rsp_tdata,   // median, median_sum
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [swm_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [swm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [swm_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   localparam int KW = $clog2(WINDOW_MAX + 1);

   logic [swm_pkg::WSIZE_W-1:0] wsize_ff, wsize_in;
   logic                        cfg_wr;
   logic [KW-1:0]               k_eff;
   logic                        q_valid, q_ready, q_restart;
   logic [VALUE_BITS-1:0]       q_value;
   swm_pkg::swm_rsp_type        rsp;
   swm_pkg::swm_status_type     stat;

   // register write decode
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite & csr_pready &
                   (csr_paddr[2] == swm_pkg::CSR_IDX_WINDOW_SIZE);
   assign wsize_in = cfg_wr ? csr_pwdata[swm_pkg::WSIZE_W-1:0] : wsize_ff;
   assign csr_prdata = (csr_paddr[2] == swm_pkg::CSR_IDX_WINDOW_SIZE) ?
                       swm_pkg::CSR_DW'(wsize_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= swm_pkg::WSIZE_W'(1);
      end else begin
         wsize_ff <= wsize_in;
      end
   end

   // effective window length, clamped to 1..WINDOW_MAX
   always_comb begin
      if (wsize_ff == '0) begin
         k_eff = KW'(1);
      end else if (32'(wsize_ff) > 32'(WINDOW_MAX)) begin
         k_eff = KW'(WINDOW_MAX);
      end else begin
         k_eff = KW'(wsize_ff);
      end
   end

   swm_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (req_tdata),
      .in_restart (req_tuser),
      .out_valid  (q_valid),
      .out_ready  (q_ready),
      .out_value  (q_value),
      .out_restart(q_restart)
   );

   swm_engine #(
      .VALUE_BITS(VALUE_BITS),
      .WINDOW_MAX(WINDOW_MAX)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_value  (q_value),
      .in_restart(q_restart),
      .cfg_k     (k_eff),
      .cfg_clear (cfg_wr),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp),
      .status    (stat)
   );

   assign rsp_tdata = rsp;

`ifndef NO_ASSERTIONS
   // no result can appear while the count memory is being zeroed
   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      stat.init |=> !$rose(rsp_tvalid))
      else $error("result produced during count memory init");

   // the window is empty throughout the init sweep
   a_empty_in_init: assert property (@(posedge clock) disable iff (reset)
      stat.init |-> (stat.fill == '0))
      else $error("window not empty during init");

   // the engine only takes a queued word while it is idle
   a_engine_busy_take: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready) |-> !stat.busy)
      else $error("engine took a word while busy");
`endif

endmodule

// File: hw/rtl/swm_front.sv
// front end: accepts sample words, masks them and queues them for the engine
module swm_front #(
   parameter int VALUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [swm_pkg::SAMPLE_W-1:0]      in_sample,
   input  logic                              in_restart,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [VALUE_BITS-1:0]             out_value,
   output logic                              out_restart
);
   localparam int EW = VALUE_BITS + 1;

   logic [EW-1:0] entry_ff [2];
   logic [1:0]    count_ff, count_in;
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [VALUE_BITS+swm_pkg::SAMPLE_W-1:0] ext;
   logic          push, pop;

   // drop sample bits above the value width, zero extend a narrower sample
   assign ext = {{VALUE_BITS{1'b0}}, in_sample};

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign {out_restart, out_value} = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {in_restart, ext[VALUE_BITS-1:0]};
      end
   end

endmodule

// File: hw/rtl/swm_engine.sv
// back end: delay line, counting trie walks, rank query and result register
module swm_engine #(
   parameter int VALUE_BITS = 16,
   parameter int WINDOW_MAX = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [VALUE_BITS-1:0]           in_value,
   input  logic                            in_restart,
   input  logic [$clog2(WINDOW_MAX+1)-1:0] cfg_k,
   input  logic                            cfg_clear,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output swm_pkg::swm_rsp_type            rsp_data,
   output swm_pkg::swm_status_type         status
);
   localparam int VB    = VALUE_BITS;
   localparam int NW    = VB + 1;
   localparam int NODES = 1 << NW;
   localparam int SW    = $clog2(VB + 1);
   localparam int KW    = $clog2(WINDOW_MAX + 1);
   localparam int PW    = $clog2(WINDOW_MAX);
   localparam int SUMW  = swm_pkg::SUM_W;

   // memories
   logic [KW-1:0] cnt_mem [NODES];
   logic [VB-1:0] win_mem [WINDOW_MAX];
   logic [KW-1:0] cnt_rd_ff;
   logic [VB-1:0] win_rd_ff;
   logic          cnt_we, win_we;
   logic [NW-1:0] cnt_waddr, cnt_raddr;
   logic [KW-1:0] cnt_wdata;
   logic [PW-1:0] win_addr;

   swm_pkg::swm_state_type state_ff, state_in, ret_ff, ret_in;
   logic            add_ff, add_in;
   logic [NW-1:0]   node_ff, node_in;
   logic [NW-1:0]   cur_ff, cur_in;
   logic [SW-1:0]   step_ff, step_in;
   logic [VB-1:0]   vsh_ff, vsh_in;
   logic            pwr_ff, pwr_in;
   logic [KW-1:0]   r_ff, r_in;
   logic [VB-1:0]   val_ff, val_in;
   logic [VB-1:0]   samp_ff, samp_in;
   logic [KW-1:0]   drain_ff, drain_in;
   logic [KW-1:0]   fill_ff, fill_in;
   logic [PW-1:0]   wp_ff, wp_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic            clr_ff, clr_in;
   logic [NW-1:0]   init_ff, init_in;
   logic            rv_ff, rv_in;
   swm_pkg::swm_rsp_type rsp_ff, rsp_in;

   logic [NW-1:0]   nxt;
   logic            go_left;
   logic [KW:0]     kp1;
   logic [KW-1:0]   fill_nx;
   logic [VB+swm_pkg::SAMPLE_W-1:0] med_ext;
   logic [SUMW:0]   sum_add;

   assign rsp_valid   = rv_ff;
   assign rsp_data    = rsp_ff;
   assign status.init = (state_ff == swm_pkg::ST_INIT);
   assign status.busy = (state_ff != swm_pkg::ST_IDLE);
   assign status.fill = swm_pkg::FILL_W'(fill_ff);

   assign kp1     = {1'b0, cfg_k} + (KW+1)'(1);
   assign go_left = (cnt_rd_ff >= r_ff);
   assign med_ext = {{swm_pkg::SAMPLE_W{1'b0}}, val_ff};
   assign sum_add = {1'b0, sum_ff} + (SUMW+1)'(med_ext[swm_pkg::SAMPLE_W-1:0]);
   assign fill_nx = (fill_ff < cfg_k) ? fill_ff + KW'(1) : fill_ff;

   // sequencer next state and memory controls
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      add_in    = add_ff;
      node_in   = node_ff;
      cur_in    = cur_ff;
      step_in   = step_ff;
      vsh_in    = vsh_ff;
      pwr_in    = pwr_ff;
      r_in      = r_ff;
      val_in    = val_ff;
      samp_in   = samp_ff;
      drain_in  = drain_ff;
      fill_in   = fill_ff;
      wp_in     = wp_ff;
      sum_in    = sum_ff;
      clr_in    = clr_ff | cfg_clear;
      init_in   = init_ff;
      rv_in     = rv_ff & ~rsp_ready;
      rsp_in    = rsp_ff;
      in_ready  = 1'b0;
      cnt_we    = 1'b0;
      cnt_waddr = cur_ff;
      cnt_wdata = add_ff ? cnt_rd_ff + KW'(1) : cnt_rd_ff - KW'(1);
      cnt_raddr = cur_ff;
      win_we    = 1'b0;
      win_addr  = wp_ff;
      nxt       = {node_ff[NW-2:0], vsh_ff[VB-1]};
      unique case (state_ff)
         // zero every trie count once after reset
         swm_pkg::ST_INIT: begin
            cnt_we    = 1'b1;
            cnt_waddr = init_ff;
            cnt_wdata = '0;
            init_in   = init_ff + NW'(1);
            if (init_ff == {NW{1'b1}}) begin
               state_in = swm_pkg::ST_IDLE;
            end
         end
         swm_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               samp_in  = in_value;
               drain_in = '0;
               state_in = (in_restart | clr_ff) ? swm_pkg::ST_DRAIN_CHK : swm_pkg::ST_PREP;
            end
         end
         // take every held sample back out of the trie
         swm_pkg::ST_DRAIN_CHK: begin
            win_addr = drain_ff[PW-1:0];
            if (drain_ff == fill_ff) begin
               fill_in  = '0;
               wp_in    = '0;
               sum_in   = '0;
               clr_in   = 1'b0;
               state_in = swm_pkg::ST_PREP;
            end else begin
               state_in = swm_pkg::ST_DRAIN_RD;
            end
         end
         swm_pkg::ST_DRAIN_RD: begin
            vsh_in   = win_rd_ff;
            add_in   = 1'b0;
            node_in  = NW'(1);
            step_in  = '0;
            pwr_in   = 1'b0;
            ret_in   = swm_pkg::ST_DRAIN_CHK;
            drain_in = drain_ff + KW'(1);
            state_in = swm_pkg::ST_WALK;
         end
         swm_pkg::ST_PREP: begin
            state_in = (fill_ff >= cfg_k) ? swm_pkg::ST_OLD_RD : swm_pkg::ST_INS;
         end
         // leaving sample comes out first
         swm_pkg::ST_OLD_RD: begin
            vsh_in   = win_rd_ff;
            add_in   = 1'b0;
            node_in  = NW'(1);
            step_in  = '0;
            pwr_in   = 1'b0;
            ret_in   = swm_pkg::ST_INS;
            state_in = swm_pkg::ST_WALK;
         end
         swm_pkg::ST_INS: begin
            win_we   = 1'b1;
            vsh_in   = samp_ff;
            add_in   = 1'b1;
            node_in  = NW'(1);
            step_in  = '0;
            pwr_in   = 1'b0;
            ret_in   = swm_pkg::ST_POST;
            state_in = swm_pkg::ST_WALK;
         end
         // one level per cycle: write back the previous level, read the next
         swm_pkg::ST_WALK: begin
            cnt_we = pwr_ff;
            if (step_ff != SW'(VB)) begin
               cnt_raddr = nxt;
               cur_in    = nxt;
               node_in   = nxt;
               vsh_in    = vsh_ff << 1;
               step_in   = step_ff + SW'(1);
               pwr_in    = 1'b1;
            end else begin
               pwr_in   = 1'b0;
               state_in = ret_ff;
            end
         end
         swm_pkg::ST_POST: begin
            wp_in   = ({1'b0, wp_ff} + (PW+1)'(1) == (PW+1)'(cfg_k)) ?
                      '0 : wp_ff + PW'(1);
            fill_in = fill_nx;
            state_in = (fill_nx >= cfg_k) ? swm_pkg::ST_RANK_START : swm_pkg::ST_IDLE;
         end
         swm_pkg::ST_RANK_START: begin
            r_in      = kp1[KW:1];
            node_in   = NW'(1);
            step_in   = '0;
            val_in    = '0;
            cnt_raddr = NW'(2);
            state_in  = swm_pkg::ST_RANK;
         end
         // descend toward the rank, left child count decides each bit
         swm_pkg::ST_RANK: begin
            nxt    = {node_ff[NW-2:0], ~go_left};
            val_in = {val_ff[VB-2:0], ~go_left};
            if (!go_left) begin
               r_in = r_ff - cnt_rd_ff;
            end
            if (step_ff != SW'(VB - 1)) begin
               cnt_raddr = {nxt[NW-2:0], 1'b0};
               node_in   = nxt;
               step_in   = step_ff + SW'(1);
            end else begin
               state_in = swm_pkg::ST_RESULT;
            end
         end
         swm_pkg::ST_RESULT: begin
            if (!rv_ff || rsp_ready) begin
               sum_in = sum_add[SUMW] ? {SUMW{1'b1}} : sum_add[SUMW-1:0];
               rsp_in.median     = med_ext[swm_pkg::SAMPLE_W-1:0];
               rsp_in.median_sum = sum_in;
               rv_in    = 1'b1;
               state_in = swm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swm_pkg::ST_INIT;
         init_ff  <= '0;
         fill_ff  <= '0;
         wp_ff    <= '0;
         sum_ff   <= '0;
         clr_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         pwr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         fill_ff  <= fill_in;
         wp_ff    <= wp_in;
         sum_ff   <= sum_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         pwr_ff   <= pwr_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ret_ff   <= ret_in;
      add_ff   <= add_in;
      node_ff  <= node_in;
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      vsh_ff   <= vsh_in;
      r_ff     <= r_in;
      val_ff   <= val_in;
      samp_ff  <= samp_in;
      drain_ff <= drain_in;
      rsp_ff   <= rsp_in;
   end

   // trie count memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // delay line memory
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_addr] <= samp_ff;
      end
      win_rd_ff <= win_mem[win_addr];
   end

endmodule
